// ===== sv/text_cell_row_generator_macros.svh =====
// Assertion macros shared by the text cell row generator RTL.
`ifndef TEXT_CELL_ROW_GENERATOR_MACROS_SVH
`define TEXT_CELL_ROW_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCRG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text cell row generator: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TCRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text cell row generator: next-cycle check failed");

`endif

// ===== sv/tcrg_pkg.sv =====
// Package with types, constants and pixel functions of the text cell row generator.
package tcrg_pkg;

  localparam int ROW_CNT_W   = 5;
  localparam int PHASE_W     = 4;
  localparam int MODE_W      = 4;
  localparam int FONT_W      = 128;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PHASE_W-1:0] MASK_ANK   = 4'd7;
  localparam logic [PHASE_W-1:0] MASK_KANJI = 4'd15;

  typedef enum logic [1:0] {
    CLS_PLAIN  = 2'd0,
    CLS_SQUASH = 2'd1,
    CLS_TALL   = 2'd2,
    CLS_NONE   = 2'd3
  } cls_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_t;

  // One classified cell, ready for the row sequencer.
  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [FONT_W-1:0]    font;
    logic [PHASE_W-1:0]   start;
    logic [PHASE_W-1:0]   step;
    logic [PHASE_W-1:0]   mask;
    logic                 paired;
    logic                 half_start;
    logic [ROW_CNT_W-1:0] count;
  } desc_t;

  // Status of the row sequencer, watched by the top level.
  typedef struct packed {
    logic running;
    logic cnt_zero;
    logic emit;
    logic emit_last;
  } bk_status_t;

  function automatic logic [7:0] widen_nibble(input logic [3:0] nib);
    widen_nibble = {nib[3], nib[3], nib[2], nib[2], nib[1], nib[1], nib[0], nib[0]};
  endfunction

  function automatic logic [7:0] apply_transform(input logic [MODE_W-1:0] mode,
                                                 input logic [7:0] b);
    if (mode[3]) begin
      apply_transform = mode[1] ? widen_nibble(b[3:0]) : widen_nibble(b[7:4]);
    end else begin
      apply_transform = mode[1] ? {b[3:0], 4'b0000} : b;
    end
  endfunction

endpackage

// ===== sv/tcrg_front.sv =====
// Front end: classifies a cell request into a sequencer descriptor.
module tcrg_front #(
  parameter int MAX_ROWS = 16
) (
  input  logic                            kind,
  input  logic [tcrg_pkg::MODE_W-1:0]     attr_mode,
  input  logic [63:0]                     font_low,
  input  logic [63:0]                     font_high,
  input  logic [tcrg_pkg::PHASE_W-1:0]    line_phase,
  input  logic [tcrg_pkg::ROW_CNT_W-1:0]  row_count,
  output logic                            has_rows,
  output tcrg_pkg::desc_t                 desc
);
  import tcrg_pkg::*;

  localparam int CNT_MAX = (1 << ROW_CNT_W) - 1;
  localparam logic [ROW_CNT_W-1:0] ROW_CLIP =
    (MAX_ROWS > CNT_MAX) ? ROW_CNT_W'(CNT_MAX) : ROW_CNT_W'(MAX_ROWS);

  cls_t                 cls;
  logic [ROW_CNT_W-1:0] n_eff;
  logic [PHASE_W-1:0]   phase_start;

  always_comb begin
    n_eff       = (row_count > ROW_CLIP) ? ROW_CLIP : row_count;
    phase_start = kind ? line_phase : {1'b0, line_phase[PHASE_W-1:1]};
    if (attr_mode[2]) begin
      cls = attr_mode[0] ? CLS_NONE : CLS_TALL;
    end else begin
      cls = attr_mode[0] ? CLS_SQUASH : CLS_PLAIN;
    end
  end

  always_comb begin
    desc.mode       = attr_mode;
    desc.font       = {font_high, font_low};
    desc.mask       = kind ? MASK_KANJI : MASK_ANK;
    desc.count      = n_eff;
    desc.start      = '0;
    desc.step       = 4'd1;
    desc.paired     = 1'b0;
    desc.half_start = 1'b0;
    case (cls)
      CLS_PLAIN: begin
        desc.step = kind ? 4'd2 : 4'd1;
      end
      CLS_SQUASH: begin
        desc.start      = phase_start;
        desc.step       = kind ? 4'd4 : 4'd2;
        desc.paired     = 1'b1;
        desc.half_start = (phase_start != '0);
      end
      CLS_TALL: begin
        desc.start  = phase_start;
        desc.paired = !kind;
      end
      default: begin
        desc.start = '0;
      end
    endcase
    has_rows = (cls != CLS_NONE) && (n_eff != '0);
  end

endmodule

// ===== sv/tcrg_queue.sv =====
// Short descriptor queue between the front end and the row sequencer.
module tcrg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcrg_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output tcrg_pkg::desc_t head
);
  import tcrg_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  desc_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == DEPTH_C);
  assign valid   = (cnt_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/tcrg_back.sv =====
// Row sequencer: walks the font rows of one cell and fills the output register.
module tcrg_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  tcrg_pkg::desc_t      q_head,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [7:0]           out_row_byte,
  output logic                 out_last,
  output tcrg_pkg::bk_status_t status
);
  import tcrg_pkg::*;

  bk_state_t            state_r, state_nxt;
  logic [MODE_W-1:0]    mode_r;
  logic [FONT_W-1:0]    font_r;
  logic [PHASE_W-1:0]   row_r, row_nxt;
  logic [PHASE_W-1:0]   step_r;
  logic [PHASE_W-1:0]   mask_r;
  logic                 paired_r;
  logic                 half_r, half_nxt;
  logic                 dup_r, dup_nxt;
  logic [ROW_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           row_byte_r;
  logic                 last_r;
  logic                 emit;
  logic                 emit_last;
  logic [PHASE_W-1:0]   idx;
  logic [7:0]           font_sel;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (emit && emit_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    case (state_r)
      BK_IDLE: q_pop = q_valid;
      BK_RUN:  emit  = !out_valid_r || out_pop;
      default: begin
        q_pop = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  always_comb begin
    emit_last = (cnt_r == ROW_CNT_W'(1));
    idx       = row_r & mask_r;
    font_sel  = font_r[{idx, 3'b000} +: 8];
  end

  // Row walk: a paired row is shown twice before the row pointer moves on.
  always_comb begin
    row_nxt  = row_r;
    half_nxt = half_r;
    dup_nxt  = dup_r;
    cnt_nxt  = cnt_r;
    if (emit) begin
      cnt_nxt = cnt_r - 1'b1;
      if (paired_r && !dup_r && !emit_last) begin
        dup_nxt = 1'b1;
      end else begin
        dup_nxt = 1'b0;
        if (half_r) begin
          row_nxt  = '0;
          half_nxt = 1'b0;
        end else begin
          row_nxt = (row_r + step_r) & mask_r;
        end
      end
    end
    out_valid_nxt = emit ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= q_pop ? q_head.count : cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mode_r   <= q_head.mode;
      font_r   <= q_head.font;
      row_r    <= q_head.start;
      step_r   <= q_head.step;
      mask_r   <= q_head.mask;
      paired_r <= q_head.paired;
      half_r   <= q_head.half_start;
      dup_r    <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      half_r <= half_nxt;
      dup_r  <= dup_nxt;
    end
    if (emit) begin
      row_byte_r <= apply_transform(mode_r, font_sel);
      last_r     <= emit_last;
    end
  end

  assign out_empty    = !out_valid_r;
  assign out_row_byte = row_byte_r;
  assign out_last     = last_r;

  always_comb begin
    status.running   = (state_r == BK_RUN);
    status.cnt_zero  = (cnt_r == '0);
    status.emit      = emit;
    status.emit_last = emit_last;
  end

endmodule

// ===== sv/text_cell_row_generator.sv =====
// Top level of the text cell row generator: front end, descriptor queue and row sequencer.
//
// Usage. The request side is a queue input: drive the cell fields and raise in_push; a
// transaction takes place at a rising edge where in_push is high and in_full is low.
// The result side is a queue output: while out_empty is low the oldest row byte stands on
// out_row_byte with out_last marking the final row of its cell, and a transaction takes
// place at a rising edge where out_pop is high and out_empty is low.
// A request transaction writes the cell into the descriptor queue; the idle sequencer then
// loads its descriptor from the queue, and each row is registered into the output register.
// The sequencer takes no new descriptor until the last row of the current cell is issued.
// Cells in an undefined attribute mode, or with a zero row count, are absorbed by the
// front end and yield no rows at all.
// A two-entry descriptor queue lets new requests be taken while a cell is still being
// walked; in_full rises only when both entries wait.
// When the receiver stalls, the current row holds in the output register and the sequencer
// waits; requests keep being taken until the queue fills.
// Reset (rst_n low at a rising edge) empties the queue, idles the sequencer and drops any
// row held in the output register.
module text_cell_row_generator #(
  parameter int MAX_ROWS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_kind,
  input  logic [3:0]  in_attr_mode,
  input  logic [63:0] in_font_low,
  input  logic [63:0] in_font_high,
  input  logic [3:0]  in_line_phase,
  input  logic [4:0]  in_row_count,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_row_byte,
  output logic        out_last
);
  import tcrg_pkg::*;

  `include "text_cell_row_generator_macros.svh"

  desc_t      fe_desc;
  logic       fe_has_rows;
  logic       q_push;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  desc_t      q_head;
  bk_status_t bk_stat;

  // The front end classifies the request combinationally; only requests that produce
  // rows are written into the queue, the rest complete their transaction and vanish.
  tcrg_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .kind       (in_kind),
    .attr_mode  (in_attr_mode),
    .font_low   (in_font_low),
    .font_high  (in_font_high),
    .line_phase (in_line_phase),
    .row_count  (in_row_count),
    .has_rows   (fe_has_rows),
    .desc       (fe_desc)
  );

  assign in_full = q_full;
  assign q_push  = in_push && !q_full && fe_has_rows;

  tcrg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (fe_desc),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // The sequencer loads one descriptor when idle and then issues one row per cycle,
  // holding whenever the output register is still occupied.
  tcrg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_row_byte (out_row_byte),
    .out_last     (out_last),
    .status       (bk_stat)
  );

  // A running sequencer always has rows left to issue.
  `TCRG_ASSERT_IMPL(a_run_has_rows, bk_stat.running, !bk_stat.cnt_zero)
  // Issuing the final row of a cell returns the sequencer to idle.
  `TCRG_ASSERT_NEXT(a_last_idles, bk_stat.emit && bk_stat.emit_last, !bk_stat.running)
  // A descriptor is only taken from the queue while the sequencer is idle.
  `TCRG_ASSERT_IMPL(a_pop_when_idle, q_pop, !bk_stat.running && q_valid)
  // A row issued into the output register is visible on the next cycle.
  `TCRG_ASSERT_NEXT(a_emit_shows, bk_stat.emit, !out_empty)

endmodule

// ===== test/text_cell_row_generator_test.sv =====
// Self-checking testbench for the text cell row generator, with its own row predictor.
module text_cell_row_generator_test;
  import tcrg_pkg::*;

  localparam int MAX_ROWS      = 16;
  localparam int RANDOM_CELLS  = 395;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_IDLE      = 17;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 60;
  localparam int DRAIN_CYCLES  = 40;
  localparam int REPORT_LIMIT  = 10;

  // Font kinds.
  localparam logic KIND_ANK   = 1'b0;
  localparam logic KIND_KANJI = 1'b1;

  // Attribute modes, by their position in the mode table.
  localparam logic [3:0] MODE_NORMAL    = 4'd0;
  localparam logic [3:0] MODE_SQUASH    = 4'd1;
  localparam logic [3:0] MODE_RIGHT4    = 4'd2;
  localparam logic [3:0] MODE_SQUASH_R4 = 4'd3;
  localparam logic [3:0] MODE_TALL      = 4'd4;
  localparam logic [3:0] MODE_UNDEF5    = 4'd5;
  localparam logic [3:0] MODE_TALL_R4   = 4'd6;
  localparam logic [3:0] MODE_UNDEF7    = 4'd7;
  localparam logic [3:0] MODE_WIDE_L    = 4'd8;
  localparam logic [3:0] MODE_SQUASH_WL = 4'd9;
  localparam logic [3:0] MODE_WIDE_R    = 4'd10;
  localparam logic [3:0] MODE_SQUASH_WR = 4'd11;
  localparam logic [3:0] MODE_QUAD_L    = 4'd12;
  localparam logic [3:0] MODE_UNDEF13   = 4'd13;
  localparam logic [3:0] MODE_QUAD_R    = 4'd14;
  localparam logic [3:0] MODE_UNDEF15   = 4'd15;

  localparam logic [63:0] FONT_STEPS = 64'h8877_6655_4433_2211;
  localparam logic [63:0] FONT_MIXED = 64'hF0E1_D2C3_B4A5_9687;
  localparam logic [63:0] FONT_HIGH  = 64'h0FED_CBA9_7531_ECA8;

  typedef struct packed {
    logic        kind;
    logic [3:0]  attr_mode;
    logic [63:0] font_low;
    logic [63:0] font_high;
    logic [3:0]  line_phase;
    logic [4:0]  row_count;
  } cell_t;

  typedef struct packed {
    logic [7:0] row_byte;
    logic       last;
  } cell_row_t;

  // A directed cell. Where typed is set, the cell yields typed_n rows (none or one) and
  // the single row, if any, is typed_byte; otherwise the predictor supplies the rows.
  typedef struct packed {
    cell_t      req;
    logic       typed;
    logic [4:0] typed_n;
    logic [7:0] typed_byte;
  } directed_cell_t;

  localparam int DIRECTED_CELLS = 25;

  directed_cell_t directed_cells [DIRECTED_CELLS] = '{
    // Smallest cell: one plain ANK row is simply font byte 0.
    '{'{KIND_ANK,   MODE_NORMAL,    FONT_MIXED, 64'h0, 4'd0,  5'd1},  1'b1, 5'd1, 8'h87},
    // A zero row count and the four undefined modes are swallowed whole.
    '{'{KIND_ANK,   MODE_NORMAL,    FONT_MIXED, 64'h0, 4'd0,  5'd0},  1'b1, 5'd0, 8'h00},
    '{'{KIND_ANK,   MODE_UNDEF5,    FONT_MIXED, 64'h0, 4'd3,  5'd16}, 1'b1, 5'd0, 8'h00},
    '{'{KIND_KANJI, MODE_UNDEF7,    '1,         '1,    4'd15, 5'd16}, 1'b1, 5'd0, 8'h00},
    '{'{KIND_ANK,   MODE_UNDEF13,   '1,         '1,    4'd7,  5'd31}, 1'b1, 5'd0, 8'h00},
    '{'{KIND_KANJI, MODE_UNDEF15,   FONT_STEPS, '1,    4'd0,  5'd1},  1'b1, 5'd0, 8'h00},
    // Pixel transforms on a single row.
    '{'{KIND_ANK,   MODE_RIGHT4,    64'hA5,     64'h0, 4'd0,  5'd1},  1'b1, 5'd1, 8'h50},
    '{'{KIND_ANK,   MODE_WIDE_L,    64'hF0,     64'h0, 4'd0,  5'd1},  1'b1, 5'd1, 8'hFF},
    '{'{KIND_ANK,   MODE_WIDE_R,    64'h05,     64'h0, 4'd0,  5'd1},  1'b1, 5'd1, 8'h33},
    '{'{KIND_KANJI, MODE_WIDE_R,    64'h0,      64'h0, 4'd15, 5'd1},  1'b1, 5'd1, 8'h00},
    // Longer walks, checked against the predictor.
    '{'{KIND_KANJI, MODE_NORMAL,    '1,         '1,    4'd15, 5'd16}, 1'b0, 5'd0, 8'h00},
    '{'{KIND_ANK,   MODE_NORMAL,    FONT_STEPS, '1,    4'd9,  5'd31}, 1'b0, 5'd0, 8'h00},
    '{'{KIND_ANK,   MODE_SQUASH,    FONT_STEPS, 64'h0, 4'd15, 5'd16}, 1'b0, 5'd0, 8'h00},
    '{'{KIND_KANJI, MODE_SQUASH,    FONT_STEPS, FONT_HIGH, 4'd5, 5'd7}, 1'b0, 5'd0, 8'h00},
    '{'{KIND_ANK,   MODE_SQUASH,    FONT_MIXED, 64'h0, 4'd1,  5'd16}, 1'b0, 5'd0, 8'h00},
    '{'{KIND_ANK,   MODE_TALL,      FONT_STEPS, 64'h0, 4'd14, 5'd9},  1'b0, 5'd0, 8'h00},
    '{'{KIND_KANJI, MODE_TALL,      FONT_STEPS, FONT_HIGH, 4'd15, 5'd16}, 1'b0, 5'd0, 8'h00},
    '{'{KIND_ANK,   MODE_SQUASH_R4, FONT_MIXED, 64'h0, 4'd6,  5'd5},  1'b0, 5'd0, 8'h00},
    '{'{KIND_KANJI, MODE_TALL_R4,   FONT_MIXED, FONT_HIGH, 4'd3, 5'd12}, 1'b0, 5'd0, 8'h00},
    '{'{KIND_ANK,   MODE_SQUASH_WL, FONT_MIXED, 64'h0, 4'd9,  5'd10}, 1'b0, 5'd0, 8'h00},
    '{'{KIND_KANJI, MODE_SQUASH_WR, FONT_MIXED, FONT_HIGH, 4'd15, 5'd16}, 1'b0, 5'd0, 8'h00},
    '{'{KIND_ANK,   MODE_QUAD_L,    FONT_MIXED, 64'h0, 4'd11, 5'd16}, 1'b0, 5'd0, 8'h00},
    '{'{KIND_KANJI, MODE_QUAD_R,    FONT_STEPS, FONT_HIGH, 4'd0, 5'd17}, 1'b0, 5'd0, 8'h00},
    '{'{KIND_KANJI, MODE_WIDE_L,    FONT_HIGH,  FONT_MIXED, 4'd8, 5'd8}, 1'b0, 5'd0, 8'h00},
    // An ANK cell must not read the upper eight font bytes.
    '{'{KIND_ANK,   MODE_NORMAL,    64'h0,      '1,    4'd0,  5'd8},  1'b0, 5'd0, 8'h00}
  };

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_push       = 1'b0;
  logic        in_full;
  logic        in_kind       = 1'b0;
  logic [3:0]  in_attr_mode  = 4'd0;
  logic [63:0] in_font_low   = 64'h0;
  logic [63:0] in_font_high  = 64'h0;
  logic [3:0]  in_line_phase = 4'd0;
  logic [4:0]  in_row_count  = 5'd0;
  logic        out_empty;
  logic        out_pop       = 1'b0;
  logic [7:0]  out_row_byte;
  logic        out_last;

  // Rows still owed by the block, oldest first.
  cell_row_t pending_rows[$];
  int        mismatch_count = 0;
  int        cycle_count    = 0;

  text_cell_row_generator #(.MAX_ROWS(MAX_ROWS)) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_kind       (in_kind),
    .in_attr_mode  (in_attr_mode),
    .in_font_low   (in_font_low),
    .in_font_high  (in_font_high),
    .in_line_phase (in_line_phase),
    .in_row_count  (in_row_count),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_row_byte  (out_row_byte),
    .out_last      (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a run that hangs is a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Widening doubles every pixel of a four-dot group, leftmost pixel first.
  function automatic logic [7:0] double_pixels(input logic [3:0] dots);
    logic [7:0] wide;
    wide = 8'h00;
    for (int i = 0; i < 4; i++) begin
      wide[2*i]     = dots[i];
      wide[2*i + 1] = dots[i];
    end
    return wide;
  endfunction

  // The pixel transform: bit 3 of the mode picks widening, bit 1 the right-hand half.
  function automatic logic [7:0] styled_row(input logic [3:0] mode, input logic [7:0] pattern);
    if (mode[3]) begin
      return mode[1] ? double_pixels(pattern[3:0]) : double_pixels(pattern[7:4]);
    end
    return mode[1] ? {pattern[3:0], 4'h0} : pattern;
  endfunction

  // Works out every row that a cell yields, queues them, and returns how many there are.
  function automatic int predict_cell_rows(input cell_t req);
    logic [127:0] font;
    cls_t         walk;
    logic [3:0]   mask;
    logic [3:0]   font_line;
    logic [3:0]   stride;
    logic         twice;
    logic         half_line;
    logic [7:0]   pattern;
    int           rows;
    int           done;
    font = {req.font_high, req.font_low};
    rows = (req.row_count > MAX_ROWS) ? MAX_ROWS : int'(req.row_count);
    if (req.attr_mode[2]) begin
      walk = req.attr_mode[0] ? CLS_NONE : CLS_TALL;
    end else begin
      walk = req.attr_mode[0] ? CLS_SQUASH : CLS_PLAIN;
    end
    if (walk == CLS_NONE || rows == 0) begin
      return 0;
    end
    mask      = req.kind ? MASK_KANJI : MASK_ANK;
    font_line = req.kind ? req.line_phase : (req.line_phase >> 1);
    stride    = 4'd1;
    twice     = 1'b0;
    half_line = 1'b0;
    case (walk)
      CLS_PLAIN: begin
        font_line = 4'd0;
        stride    = req.kind ? 4'd2 : 4'd1;
      end
      CLS_SQUASH: begin
        // A squashed cell that starts mid-cell shows its start row once more, then
        // carries on from the top of the font.
        stride    = req.kind ? 4'd4 : 4'd2;
        twice     = 1'b1;
        half_line = (font_line != 4'd0);
      end
      default: begin
        twice = !req.kind;
      end
    endcase
    done = 0;
    while (done < rows) begin
      pattern = styled_row(req.attr_mode, font[(font_line & mask) * 8 +: 8]);
      done++;
      pending_rows.push_back('{pattern, done == rows});
      // In paired walks an odd count loses the last copy.
      if (twice && done < rows) begin
        done++;
        pending_rows.push_back('{pattern, done == rows});
      end
      if (half_line) begin
        font_line = 4'd0;
        half_line = 1'b0;
      end else begin
        font_line = (font_line + stride) & mask;
      end
    end
    return rows;
  endfunction

  function automatic cell_t random_cell();
    cell_t req;
    req.kind       = 1'($urandom_range(0, 1));
    req.attr_mode  = 4'($urandom_range(0, 15));
    req.line_phase = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0:       req.font_low = 64'h0;
      1:       req.font_low = '1;
      default: req.font_low = {$urandom, $urandom};
    endcase
    req.font_high = ($urandom_range(0, 7) == 0) ? '1 : {$urandom, $urandom};
    // Mostly legal counts; now and then a zero count or one that must be cut back.
    case ($urandom_range(0, 9))
      0:       req.row_count = 5'($urandom_range(MAX_ROWS + 1, 31));
      1:       req.row_count = 5'd0;
      default: req.row_count = 5'($urandom_range(1, MAX_ROWS));
    endcase
    return req;
  endfunction

  // Gap before the next transaction. Every so often a side switches to back-to-back
  // working for a while, so that stretches with no idling at all are covered too.
  function automatic int draw_gap(inout int served, inout bit steady);
    if (served % 40 == 0) begin
      steady = ($urandom_range(0, 3) == 0);
    end
    served++;
    return steady ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  int  cells_sent  = 0;
  bit  send_steady = 1'b0;

  // Offers one cell and returns at the edge where the transaction takes place. in_push is
  // only lowered when a gap follows, so a back-to-back cell keeps it high throughout.
  task automatic offer_cell(input cell_t req);
    int gap;
    gap = draw_gap(cells_sent, send_steady);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_kind       <= req.kind;
    in_attr_mode  <= req.attr_mode;
    in_font_low   <= req.font_low;
    in_font_high  <= req.font_high;
    in_line_phase <= req.line_phase;
    in_row_count  <= req.row_count;
    do @(posedge clk); while (in_full);
  endtask

  // Result side: pops rows with random pauses and checks each against the oldest
  // expectation. Once, early in the run, it holds off for a long stretch so that the
  // descriptor queue fills and in_full has to rise while the sender keeps offering.
  initial begin : row_receiver
    int  rows_taken;
    int  pops;
    bit  steady;
    bit  held;
    int  gap;
    cell_row_t owed;
    rows_taken = 0;
    pops       = 0;
    steady     = 1'b0;
    held       = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(pops, steady);
      if (!held && rows_taken >= HOLD_AFTER) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      rows_taken++;
      if (pending_rows.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected row: row_byte %02h last %0b", out_row_byte, out_last);
        end
      end else begin
        owed = pending_rows.pop_front();
        if (out_row_byte !== owed.row_byte || out_last !== owed.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("row mismatch: expected row_byte %02h last %0b, got row_byte %02h last %0b",
                     owed.row_byte, owed.last, out_row_byte, out_last);
          end
        end
      end
    end
  end

  // Request side and overall sequencing of the run.
  initial begin : cell_sender
    cell_t req;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cells: typed expectations where the answer is obvious, the predictor
    // everywhere else.
    foreach (directed_cells[i]) begin
      offer_cell(directed_cells[i].req);
      if (directed_cells[i].typed) begin
        if (directed_cells[i].typed_n != 5'd0) begin
          pending_rows.push_back('{directed_cells[i].typed_byte, 1'b1});
        end
      end else begin
        void'(predict_cell_rows(directed_cells[i].req));
      end
    end

    // Random cells. Cells that yield nothing go in as well and count like any other.
    repeat (RANDOM_CELLS) begin
      req = random_cell();
      offer_cell(req);
      void'(predict_cell_rows(req));
    end
    in_push <= 1'b0;

    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
